FILE: rtl/cma_pkg.sv
// Shared constants, types and helper functions for the channel moving average block.
`default_nettype none

package cma_pkg;

    localparam int CHANNELS   = 4;
    localparam int MAX_WINDOW = 64;
    localparam int NUM_WIN    = 4;
    localparam int WIN_W      = 7;
    localparam int WIN_RESET  = 8;
    localparam int CH_W       = 2;
    localparam int VAL_W      = 32;
    localparam int TIME_W     = 32;

    localparam int IDX_W     = $clog2(MAX_WINDOW);
    localparam int FILL_W    = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W     = VAL_W + IDX_W;
    localparam int ADDR_W    = $clog2(CHANNELS * MAX_WINDOW);
    localparam int CHI_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W     = $clog2(SUM_W + 1);
    localparam int CFG_IDX_W = $clog2(NUM_WIN);
    localparam int CMP_W     = (FILL_W > WIN_W) ? FILL_W : WIN_W;

    typedef logic [WIN_W-1:0]         t_win;
    typedef logic [FILL_W-1:0]        t_fill;
    typedef logic signed [SUM_W-1:0]  t_sum;

    // Window register to usable length: zero acts as one, large values clamp.
    function automatic t_fill eff_window(t_win w);
        logic [CMP_W-1:0] wx;
        wx = CMP_W'(w);
        if (wx == '0) begin
            return t_fill'(1);
        end else if (wx > CMP_W'(MAX_WINDOW)) begin
            return t_fill'(MAX_WINDOW);
        end else begin
            return t_fill'(wx);
        end
    endfunction

    function automatic t_sum sext_val(logic [VAL_W-1:0] v);
        return {{(SUM_W-VAL_W){v[VAL_W-1]}}, v};
    endfunction

endpackage

`default_nettype wire

FILE: rtl/cma_if.sv
// Request channel interfaces: sample input and averaged result output.
`default_nettype none

interface cma_in_if import cma_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CH_W-1:0]          channel;
    logic [TIME_W-1:0]        sample_time;
    logic signed [VAL_W-1:0]  sample_value;
    logic                     append_flag;

    modport source (output valid, channel, sample_time, sample_value, append_flag,
                    input ready);
    modport sink   (input valid, channel, sample_time, sample_value, append_flag,
                    output ready);
endinterface

interface cma_out_if import cma_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CH_W-1:0]          out_channel;
    logic signed [VAL_W-1:0]  mean_value;
    logic [TIME_W-1:0]        mid_time;
    logic                     out_append;

    modport source (output valid, out_channel, mean_value, mid_time, out_append,
                    input ready);
    modport sink   (input valid, out_channel, mean_value, mid_time, out_append,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/channel_moving_average.sv
// Top level: per-channel moving average of timestamped samples, one result per request.
// Sequence: trim the oldest ring entry while the channel holds a full window, write the
//   sample, read the oldest time for the midpoint, then divide the sum by the fill count.
// Throughput: one request at a time, taken only when idle; the bit-serial divider
//   (one quotient bit per cycle) sets the rate, and a held result stalls the next request.
// Reset: synchronous active low; clears fill counts, sums, ring pointers and sets all
//   windows to 8. Ring contents are not cleared and are only read once written.
`default_nettype none

module channel_moving_average import cma_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [WIN_W-1:0]      i_cfg_data,
    cma_in_if.sink                i_in,
    cma_out_if.source             o_out
);

    // Sequencer states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_TRIM_RD  = 3'd1;  // ring read of oldest entry in flight
    localparam logic [2:0] S_TRIM_SUB = 3'd2;  // drop oldest from the running sum
    localparam logic [2:0] S_WRITE    = 3'd3;  // store the new sample
    localparam logic [2:0] S_OLD_RD   = 3'd4;  // read oldest time after the write
    localparam logic [2:0] S_OLD_CAP  = 3'd5;  // midpoint, divider setup
    localparam logic [2:0] S_DIV      = 3'd6;  // restoring divide, one bit a cycle
    localparam logic [2:0] S_DONE     = 3'd7;  // hand result to the output register

    // Window registers
    t_win r_win_reg [NUM_WIN];
    t_win n_win_reg [NUM_WIN];

    // Per-channel history state
    logic [IDX_W-1:0] r_oldest_mem [CHANNELS];
    logic [IDX_W-1:0] n_oldest_mem [CHANNELS];
    t_fill            r_fill_mem   [CHANNELS];
    t_fill            n_fill_mem   [CHANNELS];
    t_sum             r_sum_mem    [CHANNELS];
    t_sum             n_sum_mem    [CHANNELS];

    // Working copy of the request and the channel it touches
    logic [2:0]               r_state, n_state;
    logic [CH_W-1:0]          r_ch, n_ch;
    logic [TIME_W-1:0]        r_time, n_time;
    logic [VAL_W-1:0]         r_value, n_value;
    logic                     r_app, n_app;
    t_fill                    r_win, n_win;
    logic [IDX_W-1:0]         r_oldest, n_oldest;
    t_fill                    r_fill, n_fill;
    t_sum                     r_sum, n_sum;
    logic [TIME_W-1:0]        r_mid, n_mid;

    // Divider
    logic [SUM_W-1:0]         r_quo, n_quo;
    t_fill                    r_rem, n_rem;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic                     r_neg, n_neg;

    // Output register
    logic                     r_ovalid, n_ovalid;
    logic [CH_W-1:0]          r_och, n_och;
    logic [VAL_W-1:0]         r_omean, n_omean;
    logic [TIME_W-1:0]        r_omid, n_omid;
    logic                     r_oapp, n_oapp;

    // Sample ring: {time, value} per entry, channel-major
    logic [TIME_W+VAL_W-1:0]  mem [CHANNELS*MAX_WINDOW];
    logic [TIME_W+VAL_W-1:0]  r_rd_data;

    logic [CHI_W-1:0]         ch_idx;
    logic [CHI_W-1:0]         in_idx;
    logic [ADDR_W-1:0]        base;
    logic [ADDR_W-1:0]        rd_addr;
    logic [ADDR_W-1:0]        wr_addr;
    logic [FILL_W:0]          slot_sum;
    logic [IDX_W-1:0]         slot;
    logic                     mem_we;
    logic                     in_ready;
    logic                     in_acc;
    logic                     in_ch_ok;
    logic [FILL_W:0]          trial;
    logic                     ge;
    logic [VAL_W-1:0]         q_lo;

    assign ch_idx  = r_ch[CHI_W-1:0];
    assign in_idx  = i_in.channel[CHI_W-1:0];
    assign base    = ADDR_W'(ch_idx) * ADDR_W'(MAX_WINDOW);
    assign rd_addr = base + ADDR_W'(r_oldest);

    // Next free slot: oldest + fill, both below MAX_WINDOW, so one wrap at most
    assign slot_sum = (FILL_W+1)'(r_oldest) + (FILL_W+1)'(r_fill);
    assign slot     = (slot_sum >= (FILL_W+1)'(MAX_WINDOW)) ?
                      IDX_W'(slot_sum - (FILL_W+1)'(MAX_WINDOW)) : IDX_W'(slot_sum);
    assign wr_addr  = base + ADDR_W'(slot);
    assign mem_we   = (r_state == S_WRITE);

    assign in_ready = (r_state == S_IDLE);
    assign in_acc   = i_in.valid && in_ready;
    assign in_ch_ok = (32'(i_in.channel) < CHANNELS);

    // Restoring divide step on the magnitude of the sum
    assign trial = {r_rem, r_quo[SUM_W-1]};
    assign ge    = (trial >= (FILL_W+1)'(r_fill));
    assign q_lo  = r_quo[VAL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= {r_time, r_value};
        end
        r_rd_data <= mem[rd_addr];
    end

    always_comb begin
        n_win_reg    = r_win_reg;
        n_oldest_mem = r_oldest_mem;
        n_fill_mem   = r_fill_mem;
        n_sum_mem    = r_sum_mem;
        n_state      = r_state;
        n_ch         = r_ch;
        n_time       = r_time;
        n_value      = r_value;
        n_app        = r_app;
        n_win        = r_win;
        n_oldest     = r_oldest;
        n_fill       = r_fill;
        n_sum        = r_sum;
        n_mid        = r_mid;
        n_quo        = r_quo;
        n_rem        = r_rem;
        n_cnt        = r_cnt;
        n_neg        = r_neg;
        n_ovalid     = r_ovalid;
        n_och        = r_och;
        n_omean      = r_omean;
        n_omid       = r_omid;
        n_oapp       = r_oapp;

        if (i_cfg_we && (32'(i_cfg_idx) < NUM_WIN)) begin
            n_win_reg[i_cfg_idx] = i_cfg_data;
        end

        if (r_ovalid && o_out.ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_ch    = i_in.channel;
                    n_time  = i_in.sample_time;
                    n_value = i_in.sample_value;
                    n_app   = i_in.append_flag;
                    n_win   = eff_window(r_win_reg[i_in.channel]);
                    if (in_ch_ok) begin
                        if (i_in.append_flag) begin
                            n_oldest = r_oldest_mem[in_idx];
                            n_fill   = r_fill_mem[in_idx];
                            n_sum    = r_sum_mem[in_idx];
                        end else begin
                            n_oldest = '0;
                            n_fill   = '0;
                            n_sum    = '0;
                        end
                        n_state = S_TRIM_RD;
                    end else begin
                        // unused channel: zero result, state untouched
                        n_quo   = '0;
                        n_neg   = 1'b0;
                        n_mid   = '0;
                        n_state = S_DONE;
                    end
                end
            end
            S_TRIM_RD: begin
                if (r_fill >= r_win) begin
                    n_state = S_TRIM_SUB;
                end else begin
                    n_state = S_WRITE;
                end
            end
            S_TRIM_SUB: begin
                n_sum  = r_sum - sext_val(r_rd_data[VAL_W-1:0]);
                n_fill = r_fill - t_fill'(1);
                if (r_oldest == IDX_W'(MAX_WINDOW - 1)) begin
                    n_oldest = '0;
                end else begin
                    n_oldest = r_oldest + IDX_W'(1);
                end
                n_state = S_TRIM_RD;
            end
            S_WRITE: begin
                n_fill = r_fill + t_fill'(1);
                n_sum  = r_sum + sext_val(r_value);
                n_oldest_mem[ch_idx] = r_oldest;
                n_fill_mem[ch_idx]   = n_fill;
                n_sum_mem[ch_idx]    = n_sum;
                n_state = S_OLD_RD;
            end
            S_OLD_RD: begin
                n_state = S_OLD_CAP;
            end
            S_OLD_CAP: begin
                n_mid = TIME_W'(((TIME_W+1)'(r_rd_data[TIME_W+VAL_W-1:VAL_W]) +
                                 (TIME_W+1)'(r_time)) >> 1);
                n_neg = r_sum[SUM_W-1];
                n_quo = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
                n_rem = '0;
                n_cnt = CNT_W'(SUM_W);
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem = ge ? t_fill'(trial - (FILL_W+1)'(r_fill)) : t_fill'(trial);
                n_quo = {r_quo[SUM_W-2:0], ge};
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid = 1'b1;
                    n_och    = r_ch;
                    n_omean  = r_neg ? (~q_lo + VAL_W'(1)) : q_lo;
                    n_omid   = r_mid;
                    n_oapp   = r_app;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            for (int i = 0; i < NUM_WIN; i++) begin
                r_win_reg[i] <= t_win'(WIN_RESET);
            end
            for (int i = 0; i < CHANNELS; i++) begin
                r_oldest_mem[i] <= '0;
                r_fill_mem[i]   <= '0;
                r_sum_mem[i]    <= '0;
            end
        end else begin
            r_state      <= n_state;
            r_ovalid     <= n_ovalid;
            r_win_reg    <= n_win_reg;
            r_oldest_mem <= n_oldest_mem;
            r_fill_mem   <= n_fill_mem;
            r_sum_mem    <= n_sum_mem;
        end
        r_ch     <= n_ch;
        r_time   <= n_time;
        r_value  <= n_value;
        r_app    <= n_app;
        r_win    <= n_win;
        r_oldest <= n_oldest;
        r_fill   <= n_fill;
        r_sum    <= n_sum;
        r_mid    <= n_mid;
        r_quo    <= n_quo;
        r_rem    <= n_rem;
        r_cnt    <= n_cnt;
        r_neg    <= n_neg;
        r_och    <= n_och;
        r_omean  <= n_omean;
        r_omid   <= n_omid;
        r_oapp   <= n_oapp;
    end

    assign i_in.ready        = in_ready;
    assign o_out.valid       = r_ovalid;
    assign o_out.out_channel = r_och;
    assign o_out.mean_value  = r_omean;
    assign o_out.mid_time    = r_omid;
    assign o_out.out_append  = r_oapp;

    // Held count never exceeds the ring while a request is in work
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_state != S_DONE) |-> (r_fill <= t_fill'(MAX_WINDOW)))
        else $error("fill count above ring depth");

    // Divider never runs with a zero divisor
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_fill != '0))
        else $error("divide by zero fill count");

    // Each trim step drops exactly one entry
    a_trim_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TRIM_SUB) |=> (r_fill == t_fill'($past(r_fill) - t_fill'(1))))
        else $error("trim did not drop one entry");

    // Channel state written back matches the working count
    a_writeback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |=> (r_fill_mem[ch_idx] == r_fill))
        else $error("channel fill count write-back mismatch");

endmodule

`default_nettype wire
